/* sv/word_wrap_text_placer_macros.svh */
// Assertion macros shared by the checker of the word wrap text placer.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef WORD_WRAP_TEXT_PLACER_MACROS_SVH
`define WORD_WRAP_TEXT_PLACER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WWTP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WWTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/wwtp_pkg.sv */
// Shared widths and character codes for the word wrap text placer.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package wwtp_pkg;

	localparam int COL_W   = 6;
	localparam int ROW_W   = 5;
	localparam int GLYPH_W = 8;
	localparam int CODE_W  = 8;

	localparam logic [CODE_W-1:0] BLANK_CHAR = 8'd32;

	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;

endpackage

`default_nettype wire

/* sv/wwtp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wwtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/word_wrap_text_placer.sv */
// Word wrap text placer: gathers characters into words and places them on a
// ROW_WIDTH by ROW_COUNT screen, one output transaction per written cell.
// Depends on wwtp_pkg and wwtp_ram.
//
// A space or end of data first decides the placement and then emits the
// cells: the blanking cells of a wrapped row come first, then the word's
// cells, with no gap between them because the word store is read ahead of
// each word cell. A single cell counter walks the blanking run and the word
// store one entry per cycle while cell_stall does not hold the output.
// text_stall is high from the placement decision until the last cell has
// entered the output register, and cell_stall lengthens that run while it
// holds. A finished cell may still wait in the output register while the
// next character is taken.
`timescale 1ns / 1ps
`default_nettype none

module word_wrap_text_placer
	import wwtp_pkg::*;
#(
	parameter int ROW_WIDTH = 40,
	parameter int ROW_COUNT = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               text_valid,
	output logic                    text_stall,
	input  wire logic               action,
	input  wire logic [CODE_W-1:0]  char_code,
	output logic                    cell_valid,
	input  wire logic               cell_stall,
	output logic      [COL_W-1:0]   column,
	output logic      [ROW_W-1:0]   row,
	output logic      [GLYPH_W-1:0] glyph,
	output logic                    run_end
);

	localparam int AW = $clog2(ROW_WIDTH);
	localparam int CW = $clog2(ROW_WIDTH + 1);
	localparam int RW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BLANK,
		ST_WORD
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      word_count_q;
	logic [CW-1:0]      cursor_col_q;
	logic [RW-1:0]      cursor_row_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      last_idx_q;
	logic [CW-1:0]      start_q;
	logic               len_zero_q;
	logic               cell_valid_q;
	logic [COL_W-1:0]   column_q;
	logic [ROW_W-1:0]   row_q;
	logic [GLYPH_W-1:0] glyph_q;
	logic               run_end_q;

	logic               text_accept;
	logic               is_char;
	logic               is_place;
	logic               store_we;
	logic [CW:0]        span;
	logic               wrap;
	logic               full_word;
	logic [CW-1:0]      word_start;
	logic [RW-1:0]      next_row;
	logic               slot_free;
	logic               blank_last;
	logic               word_last;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [GLYPH_W-1:0] rd_data;

	assign text_stall  = (state_q != ST_IDLE);
	assign text_accept = text_valid && (state_q == ST_IDLE);

	assign is_char  = (action == ACT_CHAR) && (char_code != BLANK_CHAR) && (char_code != '0);
	assign is_place = ((action == ACT_CHAR) && (char_code == BLANK_CHAR))
		|| ((action == ACT_END) && (word_count_q != '0));
	assign store_we = text_accept && is_char && (word_count_q < CW'(ROW_WIDTH));

	// The word wraps when fewer than its length plus one columns remain.
	assign span       = {1'b0, cursor_col_q} + {1'b0, word_count_q};
	assign wrap       = (span >= (CW + 1)'(ROW_WIDTH));
	assign full_word  = (word_count_q == CW'(ROW_WIDTH));
	assign word_start = (wrap || (cursor_col_q == '0)) ? '0 : CW'(cursor_col_q + CW'(1));
	assign next_row   = (cursor_row_q == RW'(ROW_COUNT - 1)) ? '0 : RW'(cursor_row_q + RW'(1));

	assign slot_free  = !cell_valid_q || !cell_stall;
	assign blank_last = (idx_q == AW'(ROW_WIDTH - 1));
	assign word_last  = (idx_q == last_idx_q);

	// The store is read ahead of the cell that uses the character.
	always_comb begin
		rd_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_en = text_accept && is_place && (word_count_q != '0) && (!wrap || full_word);
			end
			ST_BLANK: begin
				rd_en = slot_free && blank_last && !len_zero_q;
			end
			ST_WORD: begin
				rd_en = slot_free && !word_last;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign rd_addr = (state_q == ST_WORD) ? AW'(idx_q + AW'(1)) : '0;

	wwtp_ram #(
		.WIDTH (GLYPH_W),
		.DEPTH (ROW_WIDTH)
	) u_word_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (word_count_q[AW-1:0]),
		.wdata (char_code),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			word_count_q <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			cell_valid_q <= 1'b0;
		end else begin
			if (cell_valid_q && !cell_stall) begin
				cell_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (text_accept) begin
						if (store_we) begin
							word_count_q <= CW'(word_count_q + CW'(1));
						end
						if (is_place) begin
							word_count_q <= '0;
							last_idx_q   <= AW'(CW'(word_count_q - CW'(1)));
							len_zero_q   <= (word_count_q == '0);
							if (wrap) begin
								cursor_row_q <= next_row;
								cursor_col_q <= word_count_q;
								start_q      <= '0;
								if (full_word) begin
									idx_q   <= '0;
									state_q <= ST_WORD;
								end else begin
									idx_q   <= word_count_q[AW-1:0];
									state_q <= ST_BLANK;
								end
							end else begin
								cursor_col_q <= CW'(word_start + word_count_q);
								start_q      <= word_start;
								idx_q        <= '0;
								if (word_count_q != '0) begin
									state_q <= ST_WORD;
								end
							end
						end
					end
				end
				ST_BLANK: begin
					if (slot_free) begin
						cell_valid_q <= 1'b1;
						column_q     <= COL_W'(idx_q);
						row_q        <= ROW_W'(cursor_row_q);
						glyph_q      <= BLANK_CHAR;
						run_end_q    <= blank_last && len_zero_q;
						if (blank_last) begin
							idx_q   <= '0;
							state_q <= len_zero_q ? ST_IDLE : ST_WORD;
						end else begin
							idx_q <= AW'(idx_q + AW'(1));
						end
					end
				end
				ST_WORD: begin
					if (slot_free) begin
						cell_valid_q <= 1'b1;
						column_q     <= COL_W'(CW'(start_q + CW'(idx_q)));
						row_q        <= ROW_W'(cursor_row_q);
						glyph_q      <= rd_data;
						run_end_q    <= word_last;
						if (word_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= AW'(idx_q + AW'(1));
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cell_valid = cell_valid_q;
	assign column     = column_q;
	assign row        = row_q;
	assign glyph      = glyph_q;
	assign run_end    = run_end_q;

endmodule

`default_nettype wire

/* sv/wwtp_checker.sv */
// Port-level checker for the word wrap text placer, bound to the top level.
// Depends on wwtp_pkg and word_wrap_text_placer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "word_wrap_text_placer_macros.svh"

module wwtp_checker
	import wwtp_pkg::*;
#(
	parameter int ROW_WIDTH = 40,
	parameter int ROW_COUNT = 24
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               text_valid,
	input wire logic               text_stall,
	input wire logic               action,
	input wire logic [CODE_W-1:0]  char_code,
	input wire logic               cell_valid,
	input wire logic               cell_stall,
	input wire logic [COL_W-1:0]   column,
	input wire logic [ROW_W-1:0]   row,
	input wire logic [GLYPH_W-1:0] glyph,
	input wire logic               run_end
);

	// A stalled cell transaction must hold its payload.
	`WWTP_ASSERT_NEXT(a_cell_hold, cell_valid && cell_stall, cell_valid && $stable(column) && $stable(row) && $stable(glyph) && $stable(run_end), "cell payload changed while stalled")

	// Every cell lands on the screen.
	`WWTP_ASSERT_NOW(a_cell_on_screen, cell_valid, (column < ROW_WIDTH) && (row < ROW_COUNT), "cell outside the screen")

	// While a run is unfinished, no new text transaction is taken.
	`WWTP_ASSERT_NOW(a_run_blocks_text, cell_valid && !run_end, text_stall, "text accepted in the middle of a cell run")

	// A plain character only fills the word store and leaves the block free.
	`WWTP_ASSERT_NEXT(a_char_no_stall, text_valid && !text_stall && (action == ACT_CHAR) && (char_code != BLANK_CHAR), !text_stall, "character transaction made the block busy")

endmodule

bind word_wrap_text_placer wwtp_checker #(
	.ROW_WIDTH (ROW_WIDTH),
	.ROW_COUNT (ROW_COUNT)
) u_wwtp_checker (.*);

`default_nettype wire
